// File: design/ghash_pkg.sv
// Package for the GHASH authenticator: field widths, mode codes, register
// indexes and the control struct passed from the top level to the core.
// No dependencies.
`default_nettype none

package ghash_pkg;

   localparam int BLOCK_W       = 128;
   localparam int HALF_W        = 64;
   localparam int MODE_W        = 2;
   localparam int VB_W          = 5;
   localparam int COUNT_W       = 61;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 64;
   localparam int BLOCK_BYTES   = 16;

   localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_AD     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TEXT   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FINISH = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HI  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LO  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_HI = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_LO = 2'd3;

   typedef logic [BLOCK_W-1:0] ghash_block_type;

   typedef struct packed {
      logic              fire;
      logic [MODE_W-1:0] mode;
      logic [VB_W-1:0]   valid_bytes;
   } ghash_step_type;

endpackage

`default_nettype wire

// File: design/ghash_if.sv
// Valid/ready channel interfaces for block items in and tag items out.
// Depends on ghash_pkg.
`default_nettype none

interface ghash_req_if import ghash_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [HALF_W-1:0] block_hi;
   logic [HALF_W-1:0] block_lo;
   logic [VB_W-1:0]   valid_bytes;

   modport source (output valid, output mode, output block_hi, output block_lo,
                   output valid_bytes, input ready);
   modport sink (input valid, input mode, input block_hi, input block_lo,
                 input valid_bytes, output ready);
endinterface

interface ghash_rsp_if import ghash_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] tag_hi;
   logic [HALF_W-1:0] tag_lo;

   modport source (output valid, output tag_hi, output tag_lo, input ready);
   modport sink (input valid, input tag_hi, input tag_lo, output ready);
endinterface

`default_nettype wire

// File: design/ghash_authenticator.sv
// GHASH authenticator top level: configuration registers, input stage,
// result register. Depends on ghash_pkg, ghash_if and ghash_core.
// A finish item leaves the input stage and its tag is captured in the result register.
// Throughput: one item per cycle, set by the combinational multiply that
// closes the accumulator loop; input stalls only while a finish meets a stalled result.
// Reset: clears key, mask, accumulator, byte counts and both valid flags.
`default_nettype none

module ghash_authenticator import ghash_pkg::*; (
   input  wire                         clock,
   input  wire                         reset,
   ghash_req_if.sink                   req,
   ghash_rsp_if.source                 rsp,
   input  wire                         csr_we,
   input  wire [CSR_INDEX_W-1:0]       csr_index,
   input  wire [CSR_DATA_W-1:0]        csr_wdata
);

   logic [HALF_W-1:0] key_hi_ff, key_lo_ff, mask_hi_ff, mask_lo_ff;

   logic              s_valid_ff, s_valid_in;
   logic [MODE_W-1:0] s_mode_ff;
   ghash_block_type   s_blk_ff;
   logic [VB_W-1:0]   s_vb_ff;

   logic              o_valid_ff, o_valid_in;
   ghash_block_type   tag_ff;

   logic              blocked;
   logic              advance;
   logic              finish_fire;
   ghash_step_type    step;
   ghash_block_type   tag;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff  <= '0;
         key_lo_ff  <= '0;
         mask_hi_ff <= '0;
         mask_lo_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_HI:  key_hi_ff  <= csr_wdata;
            CSR_KEY_LO:  key_lo_ff  <= csr_wdata;
            CSR_MASK_HI: mask_hi_ff <= csr_wdata;
            CSR_MASK_LO: mask_lo_ff <= csr_wdata;
            default:     key_hi_ff  <= key_hi_ff;
         endcase
      end
   end

   assign blocked     = s_valid_ff && (s_mode_ff == MODE_FINISH) && o_valid_ff && !rsp.ready;
   assign advance     = s_valid_ff && !blocked;
   assign finish_fire = advance && (s_mode_ff == MODE_FINISH);
   assign req.ready   = !blocked;

   assign s_valid_in = req.ready ? req.valid : s_valid_ff;
   assign o_valid_in = finish_fire ? 1'b1 : (rsp.ready ? 1'b0 : o_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s_mode_ff <= req.mode;
         s_blk_ff  <= {req.block_hi, req.block_lo};
         s_vb_ff   <= req.valid_bytes;
      end
      if (finish_fire) begin
         tag_ff <= tag;
      end
   end

   assign step.fire        = advance;
   assign step.mode        = s_mode_ff;
   assign step.valid_bytes = s_vb_ff;

   ghash_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .blk   (s_blk_ff),
      .key   ({key_hi_ff, key_lo_ff}),
      .mask  ({mask_hi_ff, mask_lo_ff}),
      .tag   (tag)
   );

   assign rsp.valid  = o_valid_ff;
   assign rsp.tag_hi = tag_ff[BLOCK_W-1:HALF_W];
   assign rsp.tag_lo = tag_ff[HALF_W-1:0];

   a_finish_gives_tag: assert property (@(posedge clock) disable iff (reset)
      finish_fire |=> o_valid_ff)
      else $error("finish item produced no tag");

   a_stall_only_on_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> s_valid_ff && o_valid_ff && !rsp.ready)
      else $error("input stalled without a pending tag");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff && !req.ready |=> s_valid_ff && $stable(s_mode_ff))
      else $error("stalled stage item lost");

endmodule

`default_nettype wire

// File: design/ghash_gfmul.sv
// Combinational GF(2^128) multiplier in GCM bit order, reduction by
// x^128 + x^7 + x^2 + x + 1. Depends on ghash_pkg.
`default_nettype none

module ghash_gfmul import ghash_pkg::*; (
   input  wire ghash_block_type x,
   input  wire ghash_block_type h,
   output ghash_block_type      z
);

   logic [BLOCK_W-1:0]   xr;
   logic [BLOCK_W-1:0]   hr;
   logic [2*BLOCK_W-2:0] prod;
   logic [BLOCK_W+6:0]   fold;
   logic [6:0]           over;
   logic [BLOCK_W-1:0]   red;

   always_comb begin
      for (int i = 0; i < BLOCK_W; i++) begin
         xr[i] = x[BLOCK_W-1-i];
         hr[i] = h[BLOCK_W-1-i];
      end
      prod = '0;
      for (int i = 0; i < BLOCK_W; i++) begin
         if (xr[i]) begin
            prod = prod ^ ({{(BLOCK_W-1){1'b0}}, hr} << i);
         end
      end
      // fold degrees 128..254 back, then the small overflow once more
      fold = {7'b0, prod[BLOCK_W-1:0]}
           ^ {8'b0, prod[2*BLOCK_W-2:BLOCK_W]}
           ^ ({8'b0, prod[2*BLOCK_W-2:BLOCK_W]} << 1)
           ^ ({8'b0, prod[2*BLOCK_W-2:BLOCK_W]} << 2)
           ^ ({8'b0, prod[2*BLOCK_W-2:BLOCK_W]} << 7);
      over = fold[BLOCK_W+6:BLOCK_W];
      red  = fold[BLOCK_W-1:0]
           ^ {{(BLOCK_W-7){1'b0}}, over}
           ^ ({{(BLOCK_W-7){1'b0}}, over} << 1)
           ^ ({{(BLOCK_W-7){1'b0}}, over} << 2)
           ^ ({{(BLOCK_W-7){1'b0}}, over} << 7);
      for (int i = 0; i < BLOCK_W; i++) begin
         z[i] = red[BLOCK_W-1-i];
      end
   end

endmodule

`default_nettype wire

// File: design/ghash_core.sv
// Accumulator and byte counts with the per-item update: padding, length block,
// multiply by H and tag masking. Depends on ghash_pkg and ghash_gfmul.
`default_nettype none

module ghash_core import ghash_pkg::*; (
   input  wire                  clock,
   input  wire                  reset,
   input  wire ghash_step_type  step,
   input  wire ghash_block_type blk,
   input  wire ghash_block_type key,
   input  wire ghash_block_type mask,
   output ghash_block_type      tag
);

   ghash_block_type    acc_ff, acc_in;
   logic [COUNT_W-1:0] ad_count_ff, ad_count_in;
   logic [COUNT_W-1:0] text_count_ff, text_count_in;
   logic [VB_W-1:0]    vb_sat;
   ghash_block_type    byte_mask;
   ghash_block_type    len_block;
   ghash_block_type    operand;
   ghash_block_type    product;
   logic               is_finish;

   assign is_finish = (step.mode == MODE_FINISH);
   assign vb_sat    = (step.valid_bytes > VB_W'(BLOCK_BYTES)) ?
                      VB_W'(BLOCK_BYTES) : step.valid_bytes;
   assign len_block = {ad_count_ff, 3'b000, text_count_ff, 3'b000};

   always_comb begin
      for (int k = 0; k < BLOCK_BYTES; k++) begin
         byte_mask[BLOCK_W-1-8*k -: 8] = (VB_W'(k) < vb_sat) ? 8'hFF : 8'h00;
      end
   end

   assign operand = acc_ff ^ (is_finish ? len_block : (blk & byte_mask));

   ghash_gfmul u_gfmul (
      .x (operand),
      .h (key),
      .z (product)
   );

   assign tag = product ^ mask;

   always_comb begin
      acc_in        = acc_ff;
      ad_count_in   = ad_count_ff;
      text_count_in = text_count_ff;
      if (step.fire) begin
         case (step.mode)
            MODE_START, MODE_FINISH: begin
               acc_in        = '0;
               ad_count_in   = '0;
               text_count_in = '0;
            end
            MODE_AD: begin
               if (vb_sat != '0) begin
                  acc_in      = product;
                  ad_count_in = ad_count_ff + {{(COUNT_W-VB_W){1'b0}}, vb_sat};
               end
            end
            MODE_TEXT: begin
               if (vb_sat != '0) begin
                  acc_in        = product;
                  text_count_in = text_count_ff + {{(COUNT_W-VB_W){1'b0}}, vb_sat};
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         ad_count_ff   <= '0;
         text_count_ff <= '0;
      end else begin
         acc_ff        <= acc_in;
         ad_count_ff   <= ad_count_in;
         text_count_ff <= text_count_in;
      end
   end

   a_clear_on_bounds: assert property (@(posedge clock) disable iff (reset)
      step.fire && (step.mode == MODE_START || step.mode == MODE_FINISH)
      |=> acc_ff == '0 && ad_count_ff == '0 && text_count_ff == '0)
      else $error("message state not cleared after start or finish");

   a_empty_block_holds: assert property (@(posedge clock) disable iff (reset)
      step.fire && step.valid_bytes == '0
      && (step.mode == MODE_AD || step.mode == MODE_TEXT)
      |=> $stable(acc_ff) && $stable(ad_count_ff) && $stable(text_count_ff))
      else $error("empty data block changed message state");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking bench for ghash_authenticator: directed plan, then random messages,
// with tags checked against a GF(2^128) GHASH predictor or a fixed tag in the plan.
// Depends on ghash_pkg, ghash_if and the design top level.
`default_nettype none

module tb_top;
   import ghash_pkg::*;

   localparam int ITEM_TARGET   = 800;
   localparam int SETTLE_CYCLES = 6;
   localparam int STALL_LIMIT   = 2000;
   localparam int CALM_FROM     = 300;
   localparam int CALM_UNTIL    = 700;
   localparam ghash_block_type GF_POLY  = {64'hE100_0000_0000_0000, 64'h0};
   localparam ghash_block_type KEY_ONE  = {1'b1, 127'b0};
   localparam logic [HALF_W-1:0] ONES   = '1;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [HALF_W-1:0] block_hi;
      logic [HALF_W-1:0] block_lo;
      logic [VB_W-1:0]   valid_bytes;
   } ghash_item_type;

   typedef struct packed {
      logic                   reg_write;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_value;
      ghash_item_type         item;
      logic                   typed;
      ghash_block_type        tag;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ghash_req_if req_ch ();
   ghash_rsp_if rsp_ch ();

   ghash_authenticator dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ghash_block_type hash_key;
   ghash_block_type tag_mask;
   ghash_block_type running_hash;
   logic [COUNT_W-1:0] ad_bytes;
   logic [COUNT_W-1:0] text_bytes;

   ghash_block_type pending_tags [$];
   plan_row_type    plan [$];
   int unsigned     cycle_no = 0;
   int              errors = 0;
   int              live_items = 0;
   logic            unsettled = 1'b0;

   function automatic bit idle_now();
      return (cycle_no < CALM_FROM || cycle_no >= CALM_UNTIL) && $urandom_range(0, 99) < 19;
   endfunction

   function automatic ghash_block_type gf_times_key(ghash_block_type x, ghash_block_type h);
      ghash_block_type z;
      ghash_block_type v;
      z = '0;
      v = h;
      for (int i = BLOCK_W - 1; i >= 0; i--) begin
         if (x[i]) z ^= v;
         v = v[0] ? ((v >> 1) ^ GF_POLY) : (v >> 1);
      end
      return z;
   endfunction

   function automatic bit step_ghash(input ghash_item_type it, output ghash_block_type tag);
      ghash_block_type keep;
      int unsigned n;
      tag = '0;
      case (it.mode)
         MODE_START: begin
            running_hash = '0;
            ad_bytes = '0;
            text_bytes = '0;
         end
         MODE_FINISH: begin
            running_hash = gf_times_key(running_hash ^ {ad_bytes, 3'b000, text_bytes, 3'b000},
                                        hash_key);
            tag = running_hash ^ tag_mask;
            running_hash = '0;
            ad_bytes = '0;
            text_bytes = '0;
            return 1'b1;
         end
         default: begin
            if (it.valid_bytes != 0) begin
               n = (it.valid_bytes > BLOCK_BYTES) ? BLOCK_BYTES : it.valid_bytes;
               keep = {BLOCK_W{1'b1}} << (BLOCK_W - 8 * n);
               running_hash = gf_times_key(running_hash ^ ({it.block_hi, it.block_lo} & keep),
                                           hash_key);
               if (it.mode == MODE_AD) ad_bytes = ad_bytes + COUNT_W'(n);
               else text_bytes = text_bytes + COUNT_W'(n);
            end
         end
      endcase
      return 1'b0;
   endfunction

   function automatic ghash_item_type make_item(logic [MODE_W-1:0] mode, logic [HALF_W-1:0] hi,
                                                logic [HALF_W-1:0] lo, logic [VB_W-1:0] vb);
      ghash_item_type it;
      it.mode = mode;
      it.block_hi = hi;
      it.block_lo = lo;
      it.valid_bytes = vb;
      return it;
   endfunction

   function automatic plan_row_type item_row(logic [MODE_W-1:0] mode, logic [HALF_W-1:0] hi,
                                             logic [HALF_W-1:0] lo, logic [VB_W-1:0] vb);
      plan_row_type r;
      r = '0;
      r.item = make_item(mode, hi, lo, vb);
      return r;
   endfunction

   function automatic plan_row_type finish_row(ghash_block_type tag);
      plan_row_type r;
      r = '0;
      r.item = make_item(MODE_FINISH, ONES, ONES, 5'd16);
      r.typed = 1'b1;
      r.tag = tag;
      return r;
   endfunction

   function automatic plan_row_type reg_row(logic [CSR_INDEX_W-1:0] index,
                                            logic [CSR_DATA_W-1:0] value);
      plan_row_type r;
      r = '0;
      r.reg_write = 1'b1;
      r.reg_index = index;
      r.reg_value = value;
      return r;
   endfunction

   task automatic drain_pipeline();
      if (unsettled) begin
         req_ch.valid <= 1'b0;
         while (pending_tags.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         unsettled = 1'b0;
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      drain_pipeline();
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_KEY_HI:  hash_key[BLOCK_W-1:HALF_W] = value;
         CSR_KEY_LO:  hash_key[HALF_W-1:0] = value;
         CSR_MASK_HI: tag_mask[BLOCK_W-1:HALF_W] = value;
         CSR_MASK_LO: tag_mask[HALF_W-1:0] = value;
         default: ;
      endcase
   endtask

   task automatic offer_block(input ghash_item_type it, input logic typed,
                              input ghash_block_type typed_tag);
      ghash_block_type tag;
      csr_we <= 1'b0;
      if (idle_now()) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while (idle_now());
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= it.mode;
      req_ch.block_hi <= it.block_hi;
      req_ch.block_lo <= it.block_lo;
      req_ch.valid_bytes <= it.valid_bytes;
      do @(posedge clock); while (!req_ch.ready);
      unsettled = 1'b1;
      if (it.mode == MODE_START || it.mode == MODE_FINISH || it.valid_bytes != 0)
         live_items++;
      if (step_ghash(it, tag)) pending_tags.push_back(typed ? typed_tag : tag);
   endtask

   initial begin
      ghash_block_type key;
      ghash_block_type mask;
      logic [MODE_W-1:0] mode;
      logic [VB_W-1:0] vb;
      int n_ad;
      int n_text;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_KEY_HI;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_START;
      req_ch.block_hi = '0;
      req_ch.block_lo = '0;
      req_ch.valid_bytes = '0;
      hash_key = '0;
      tag_mask = '0;
      running_hash = '0;
      ad_bytes = '0;
      text_bytes = '0;
      plan = {
         item_row(MODE_START, ONES, ONES, 5'd31),
         item_row(MODE_AD, ONES, ONES, 5'd16),
         finish_row('0),
         reg_row(CSR_KEY_HI, KEY_ONE[BLOCK_W-1:HALF_W]),
         reg_row(CSR_KEY_LO, KEY_ONE[HALF_W-1:0]),
         item_row(MODE_AD, ONES, ONES, 5'd16),
         finish_row({64'hFFFF_FFFF_FFFF_FF7F, 64'hFFFF_FFFF_FFFF_FFFF}),
         item_row(MODE_TEXT, ONES, ONES, 5'd1),
         finish_row({64'hFF00_0000_0000_0000, 64'h0000_0000_0000_0008}),
         item_row(MODE_TEXT, ONES, ONES, 5'd0),
         item_row(MODE_TEXT, ONES, ONES, 5'd31),
         finish_row({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF7F}),
         item_row(MODE_AD, ONES, ONES, 5'd9),
         item_row(MODE_START, ONES, ONES, 5'd16),
         item_row(MODE_TEXT, 64'h0, 64'h0, 5'd16),
         finish_row({64'h0, 64'h0000_0000_0000_0080}),
         finish_row('0),
         reg_row(CSR_MASK_HI, ONES),
         reg_row(CSR_MASK_LO, ONES),
         finish_row('1),
         reg_row(CSR_KEY_HI, ONES),
         reg_row(CSR_KEY_LO, ONES),
         reg_row(CSR_MASK_HI, 64'h0123_4567_89AB_CDEF),
         reg_row(CSR_MASK_LO, 64'hFEDC_BA98_7654_3210),
         item_row(MODE_AD, 64'hA5A5_5A5A_0F0F_F0F0, 64'h1234_5678_9ABC_DEF0, 5'd5),
         item_row(MODE_TEXT, 64'hDEAD_BEEF_CAFE_F00D, 64'h0BAD_F00D_1357_9BDF, 5'd12),
         item_row(MODE_AD, 64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE, 5'd3),
         item_row(MODE_FINISH, 64'h0, 64'h0, 5'd0),
         item_row(MODE_AD, 64'h0F1E_2D3C_4B5A_6978, 64'h8796_A5B4_C3D2_E1F0, 5'd8),
         item_row(MODE_TEXT, 64'h5555_AAAA_3333_CCCC, 64'h6666_9999_FFFF_0000, 5'd15),
         item_row(MODE_FINISH, 64'h0, 64'h0, 5'd16),
         item_row(MODE_AD, 64'h0, 64'h0, 5'd16),
         item_row(MODE_FINISH, 64'h0, 64'h0, 5'd16)
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].reg_write) write_reg(plan[i].reg_index, plan[i].reg_value);
         else offer_block(plan[i].item, plan[i].typed, plan[i].tag);
      end

      while (live_items < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 5))
               0: key = '0;
               1: key = '1;
               2: key = KEY_ONE;
               default: key = {$urandom, $urandom, $urandom, $urandom};
            endcase
            case ($urandom_range(0, 3))
               0: mask = '0;
               1: mask = '1;
               default: mask = {$urandom, $urandom, $urandom, $urandom};
            endcase
            write_reg(CSR_KEY_HI, key[BLOCK_W-1:HALF_W]);
            write_reg(CSR_KEY_LO, key[HALF_W-1:0]);
            write_reg(CSR_MASK_HI, mask[BLOCK_W-1:HALF_W]);
            write_reg(CSR_MASK_LO, mask[HALF_W-1:0]);
         end
         if ($urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 9) < 7)
               offer_block(make_item(MODE_START, {$urandom, $urandom}, {$urandom, $urandom},
                                     VB_W'($urandom_range(0, 31))), 1'b0, '0);
            n_ad = $urandom_range(0, 3);
            n_text = $urandom_range(0, 5);
            for (int k = 0; k < n_ad + n_text; k++) begin
               mode = (k < n_ad) ? MODE_AD : MODE_TEXT;
               if (k == n_ad + n_text - 1 && $urandom_range(0, 3) == 0) mode = MODE_AD;
               vb = (k == n_ad - 1 || k == n_ad + n_text - 1) ?
                    VB_W'($urandom_range(1, 16)) : VB_W'(16);
               offer_block(make_item(mode, {$urandom, $urandom}, {$urandom, $urandom}, vb),
                           1'b0, '0);
            end
            offer_block(make_item(MODE_FINISH, {$urandom, $urandom}, {$urandom, $urandom},
                                  VB_W'($urandom_range(0, 31))), 1'b0, '0);
         end else begin
            repeat ($urandom_range(1, 4))
               offer_block(make_item(MODE_W'($urandom_range(0, 3)), {$urandom, $urandom},
                                     {$urandom, $urandom}, VB_W'($urandom_range(0, 31))),
                           1'b0, '0);
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_tags.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      ghash_block_type due;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_tags.size() == 0) begin
               $display("%0t unexpected tag: expected none actual %h_%h", $time,
                        rsp_ch.tag_hi, rsp_ch.tag_lo);
               errors++;
            end else begin
               due = pending_tags.pop_front();
               if (rsp_ch.tag_hi !== due[BLOCK_W-1:HALF_W]) begin
                  $display("%0t tag_hi mismatch: expected %h actual %h", $time,
                           due[BLOCK_W-1:HALF_W], rsp_ch.tag_hi);
                  errors++;
               end
               if (rsp_ch.tag_lo !== due[HALF_W-1:0]) begin
                  $display("%0t tag_lo mismatch: expected %h actual %h", $time,
                           due[HALF_W-1:0], rsp_ch.tag_lo);
                  errors++;
               end
            end
         end
         rsp_ch.ready <= !reset && !idle_now();
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         cycle_no <= cycle_no + 1;
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t watchdog: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
